FILE: rtl/mat4_transform_engine_assert.svh
// assertion macros for the 4x4 matrix transform engine
// expects clk and rst_n in the scope of each use
`ifndef MAT4_TRANSFORM_ENGINE_ASSERT_SVH
`define MAT4_TRANSFORM_ENGINE_ASSERT_SVH

// same-cycle implication
`define MTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mte_pkg.sv
// shared types, codes and saturation helper for the matrix transform engine
// no dependencies
package mte_pkg;

    localparam int WORD_BITS = 32;
    localparam int SAT_BITS  = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 2) ? 2 : WORD_BITS);
    localparam int DATA_BITS = 32;
    localparam int ACC_BITS  = 50;
    localparam int ONE_Q     = 65536;

    localparam logic signed [ACC_BITS-1:0] SAT_MAX =
        ACC_BITS'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);

    // item kinds
    localparam logic [3:0] KIND_IDENT     = 4'd0;
    localparam logic [3:0] KIND_WR_CUR    = 4'd1;
    localparam logic [3:0] KIND_WR_OPR    = 4'd2;
    localparam logic [3:0] KIND_COMPOSE   = 4'd3;
    localparam logic [3:0] KIND_TRANSLATE = 4'd4;
    localparam logic [3:0] KIND_SCALE     = 4'd5;
    localparam logic [3:0] KIND_POINT     = 4'd6;
    localparam logic [3:0] KIND_DIR       = 4'd7;
    localparam logic [3:0] KIND_READ      = 4'd8;

    // term sources
    localparam logic [2:0] SRC_PROD_OP = 3'd0;
    localparam logic [2:0] SRC_PROD_X  = 3'd1;
    localparam logic [2:0] SRC_PROD_Y  = 3'd2;
    localparam logic [2:0] SRC_PROD_Z  = 3'd3;
    localparam logic [2:0] SRC_CUR     = 3'd4;
    localparam logic [2:0] SRC_TMP     = 3'd5;
    localparam logic [2:0] SRC_EV      = 3'd6;
    localparam logic [2:0] SRC_ONE     = 3'd7;

    // result destinations
    localparam logic [1:0] DEST_CUR  = 2'd0;
    localparam logic [1:0] DEST_OPR  = 2'd1;
    localparam logic [1:0] DEST_TMP  = 2'd2;
    localparam logic [1:0] DEST_EMIT = 2'd3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic       valid;
        logic       capture;
        logic       zero;
        logic [2:0] src;
        logic [3:0] a_addr;
        logic [3:0] b_addr;
        logic       first;
        logic       last;
        logic [1:0] dest;
        logic [3:0] waddr;
        logic [1:0] comp_idx;
        logic       emit_last;
    } ctl_cmd_t;

    typedef struct packed {
        logic               busy;
        logic [FIFO_CW-1:0] fifo_free;
    } dp_stat_t;

    function automatic logic [DATA_BITS-1:0] sat_word(input logic signed [ACC_BITS-1:0] v);
        logic [DATA_BITS-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[DATA_BITS-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[DATA_BITS-1:0];
        end
        else
        begin
            r = v[DATA_BITS-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/mte_req_if.sv
// request channel: one item of the matrix transform engine
// depends on nothing
interface mte_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         kind;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;

    modport source (output valid, kind, elem_index, elem_value, coord_x, coord_y, coord_z,
                    input ready);
    modport sink (input valid, kind, elem_index, elem_value, coord_x, coord_y, coord_z,
                  output ready);
endinterface

FILE: rtl/mte_res_if.sv
// result channel: one component item of the matrix transform engine
// depends on nothing
interface mte_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] component_value;
    logic [1:0]         component_index;
    logic               last;

    modport source (output valid, component_value, component_index, last, input ready);
    modport sink (input valid, component_value, component_index, last, output ready);
endinterface

FILE: rtl/mte_ctrl.sv
// sequencer of the matrix transform engine: one step command per cycle while running
// depends on mte_pkg and the assertion macro header
`include "mat4_transform_engine_assert.svh"

module mte_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [3:0]         req_kind,
    input  logic [3:0]         req_index,
    input  mte_pkg::dp_stat_t  stat,
    output logic               idle,
    output mte_pkg::ctl_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPACE = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_COPY  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [3:0] kind_reg, kind_next;
    logic [3:0] idx_reg, idx_next;
    logic [5:0] step_reg, step_next;
    logic [5:0] last_step;
    logic [2:0] need;
    logic [1:0] row, k, col;
    logic [2:0] coord_src;
    logic       accept;

    assign idle   = (state_reg == ST_IDLE);
    assign accept = idle && req_valid;
    assign row    = step_reg[3:2];
    assign k      = step_reg[1:0];
    assign col    = step_reg[5:4];
    assign coord_src = (k == 2'd0) ? mte_pkg::SRC_PROD_X :
                       (k == 2'd1) ? mte_pkg::SRC_PROD_Y : mte_pkg::SRC_PROD_Z;

    always_comb
    begin
        case (kind_reg)
            mte_pkg::KIND_IDENT, mte_pkg::KIND_TRANSLATE, mte_pkg::KIND_POINT:
                last_step = 6'd15;
            mte_pkg::KIND_COMPOSE:
                last_step = 6'd63;
            mte_pkg::KIND_SCALE, mte_pkg::KIND_DIR:
                last_step = 6'd11;
            default:
                last_step = 6'd0;
        endcase
        case (kind_reg)
            mte_pkg::KIND_POINT: need = 3'd4;
            mte_pkg::KIND_DIR:   need = 3'd3;
            default:             need = 3'd1;
        endcase
    end

    // step command generation
    always_comb
    begin
        cmd           = '0;
        cmd.capture   = accept;
        cmd.first     = 1'b1;
        cmd.last      = 1'b1;
        if (state_reg == ST_COPY)
        begin
            cmd.valid  = 1'b1;
            cmd.src    = mte_pkg::SRC_TMP;
            cmd.a_addr = step_reg[3:0];
            cmd.dest   = mte_pkg::DEST_CUR;
            cmd.waddr  = step_reg[3:0];
        end
        else if (state_reg == ST_RUN)
        begin
            cmd.valid = 1'b1;
            case (kind_reg)
                mte_pkg::KIND_IDENT:
                begin
                    cmd.src   = mte_pkg::SRC_ONE;
                    cmd.zero  = !(step_reg[3:0] inside {4'd0, 4'd5, 4'd10, 4'd15});
                    cmd.dest  = mte_pkg::DEST_CUR;
                    cmd.waddr = step_reg[3:0];
                end
                mte_pkg::KIND_WR_CUR, mte_pkg::KIND_WR_OPR:
                begin
                    cmd.src   = mte_pkg::SRC_EV;
                    cmd.dest  = (kind_reg == mte_pkg::KIND_WR_CUR) ?
                                mte_pkg::DEST_CUR : mte_pkg::DEST_OPR;
                    cmd.waddr = idx_reg;
                end
                mte_pkg::KIND_COMPOSE:
                begin
                    cmd.src    = mte_pkg::SRC_PROD_OP;
                    cmd.a_addr = {k, row};
                    cmd.b_addr = {col, k};
                    cmd.first  = (k == 2'd0);
                    cmd.last   = (k == 2'd3);
                    cmd.dest   = mte_pkg::DEST_TMP;
                    cmd.waddr  = {col, row};
                end
                mte_pkg::KIND_TRANSLATE, mte_pkg::KIND_POINT, mte_pkg::KIND_DIR:
                begin
                    cmd.src    = (k == 2'd3) ? mte_pkg::SRC_CUR : coord_src;
                    cmd.zero   = (k == 2'd3) && (kind_reg == mte_pkg::KIND_DIR);
                    cmd.a_addr = {k, row};
                    cmd.first  = (k == 2'd0);
                    cmd.last   = (k == 2'd3);
                    cmd.dest   = (kind_reg == mte_pkg::KIND_TRANSLATE) ?
                                 mte_pkg::DEST_CUR : mte_pkg::DEST_EMIT;
                    cmd.waddr  = {2'd3, row};
                    cmd.comp_idx  = row;
                    cmd.emit_last = (kind_reg == mte_pkg::KIND_POINT) ? (row == 2'd3)
                                                                      : (row == 2'd2);
                end
                mte_pkg::KIND_SCALE:
                begin
                    cmd.src    = (step_reg[3:2] == 2'd0) ? mte_pkg::SRC_PROD_X :
                                 (step_reg[3:2] == 2'd1) ? mte_pkg::SRC_PROD_Y :
                                 mte_pkg::SRC_PROD_Z;
                    cmd.a_addr = step_reg[3:0];
                    cmd.dest   = mte_pkg::DEST_CUR;
                    cmd.waddr  = step_reg[3:0];
                end
                mte_pkg::KIND_READ:
                begin
                    cmd.src       = mte_pkg::SRC_CUR;
                    cmd.a_addr    = idx_reg;
                    cmd.dest      = mte_pkg::DEST_EMIT;
                    cmd.emit_last = 1'b1;
                end
                default:
                begin
                    cmd.valid = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = req_kind;
                    idx_next  = req_index;
                    step_next = '0;
                    if (req_kind inside {mte_pkg::KIND_POINT, mte_pkg::KIND_DIR,
                                         mte_pkg::KIND_READ})
                    begin
                        state_next = ST_SPACE;
                    end
                    else if (req_kind <= mte_pkg::KIND_READ)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_SPACE:
            begin
                if (stat.fifo_free >= need)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg == last_step)
                begin
                    step_next  = '0;
                    state_next = (kind_reg == mte_pkg::KIND_COMPOSE) ? ST_COPY : ST_DRAIN;
                end
            end
            ST_COPY:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg[3:0] == 4'd15)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    `MTE_ASSERT_NOW(a_cmd_in_run, cmd.valid, state_reg == ST_RUN || state_reg == ST_COPY, "step issued outside run")
    `MTE_ASSERT_NOW(a_idle_empty, state_reg == ST_IDLE, !stat.busy, "pipeline busy while idle")
    `MTE_ASSERT_NEXT(a_accept_leaves, accept, state_reg != ST_IDLE, "accepted item left idle")

endmodule

FILE: rtl/mte_dpath.sv
// datapath: matrices, one multiplier, accumulator, saturation and result fifo
// depends on mte_pkg
module mte_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  mte_pkg::ctl_cmd_t  cmd,
    input  logic signed [31:0] req_value,
    input  logic signed [31:0] req_x,
    input  logic signed [31:0] req_y,
    input  logic signed [31:0] req_z,
    output mte_pkg::dp_stat_t  stat,
    output logic               res_valid,
    input  logic               res_ready,
    output logic signed [31:0] res_value,
    output logic [1:0]         res_index,
    output logic               res_last
);

    localparam int DW = mte_pkg::DATA_BITS;
    localparam int AW = mte_pkg::ACC_BITS;
    localparam logic [DW-1:0] ONE_RESET =
        mte_pkg::sat_word(AW'(mte_pkg::ONE_Q));

    typedef logic [mte_pkg::FIFO_CW-1:0] fifo_cnt_t;

    logic [DW-1:0] cur_reg [16];
    logic [DW-1:0] opr_reg [16];
    logic [DW-1:0] tmp_reg [16];
    logic signed [DW-1:0] ev_reg, x_reg, y_reg, z_reg;

    logic signed [DW-1:0]   mul_a, mul_b;
    logic signed [2*DW-1:0] prod;
    logic signed [AW-1:0]   term;

    logic                 s1_valid_reg;
    mte_pkg::ctl_cmd_t    s1_ctl_reg;
    logic signed [AW-1:0] term_reg;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic                 s2_valid_reg;
    mte_pkg::ctl_cmd_t    s2_ctl_reg;
    logic [DW-1:0]        res_word;

    logic [DW+2:0]              fifo_mem [mte_pkg::FIFO_DEPTH];
    logic [mte_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    fifo_cnt_t                   count_reg;
    logic push, pop;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ev_reg <= req_value;
            x_reg  <= req_x;
            y_reg  <= req_y;
            z_reg  <= req_z;
        end
    end

    // term select and floored product
    always_comb
    begin
        mul_a = $signed(cur_reg[cmd.a_addr]);
        case (cmd.src)
            mte_pkg::SRC_PROD_OP: mul_b = $signed(opr_reg[cmd.b_addr]);
            mte_pkg::SRC_PROD_X:  mul_b = x_reg;
            mte_pkg::SRC_PROD_Y:  mul_b = y_reg;
            mte_pkg::SRC_PROD_Z:  mul_b = z_reg;
            default:              mul_b = '0;
        endcase
        prod = mul_a * mul_b;
        case (cmd.src)
            mte_pkg::SRC_CUR: term = AW'(mul_a);
            mte_pkg::SRC_TMP: term = AW'($signed(tmp_reg[cmd.a_addr]));
            mte_pkg::SRC_EV:  term = AW'(ev_reg);
            mte_pkg::SRC_ONE: term = AW'(mte_pkg::ONE_Q);
            default:          term = AW'(prod >>> 16);
        endcase
        if (cmd.zero)
        begin
            term = '0;
        end
    end

    assign acc_next = (s1_ctl_reg.first ? '0 : acc_reg) + term_reg;
    assign res_word = mte_pkg::sat_word(acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.valid;
            s2_valid_reg <= s1_valid_reg && s1_ctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ctl_reg <= cmd;
        term_reg   <= term;
        if (s1_valid_reg)
        begin
            acc_reg    <= acc_next;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // matrix write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                cur_reg[i] <= (i % 5 == 0) ? ONE_RESET : '0;
                opr_reg[i] <= '0;
            end
        end
        else if (s2_valid_reg)
        begin
            if (s2_ctl_reg.dest == mte_pkg::DEST_CUR)
            begin
                cur_reg[s2_ctl_reg.waddr] <= res_word;
            end
            if (s2_ctl_reg.dest == mte_pkg::DEST_OPR)
            begin
                opr_reg[s2_ctl_reg.waddr] <= res_word;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_ctl_reg.dest == mte_pkg::DEST_TMP)
        begin
            tmp_reg[s2_ctl_reg.waddr] <= res_word;
        end
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= {res_word, s2_ctl_reg.comp_idx, s2_ctl_reg.emit_last};
        end
    end

    // result fifo
    assign push = s2_valid_reg && (s2_ctl_reg.dest == mte_pkg::DEST_EMIT);
    assign pop  = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + fifo_cnt_t'(push) - fifo_cnt_t'(pop);
        end
    end

    assign res_valid = (count_reg != '0);
    assign res_value = $signed(fifo_mem[rd_ptr_reg][DW+2:3]);
    assign res_index = fifo_mem[rd_ptr_reg][2:1];
    assign res_last  = fifo_mem[rd_ptr_reg][0];

    assign stat.busy      = s1_valid_reg || s2_valid_reg;
    assign stat.fifo_free = fifo_cnt_t'(mte_pkg::FIFO_DEPTH) - count_reg;

endmodule

FILE: rtl/mat4_transform_engine.sv
// Column-major 4x4 Q16.16 matrix transform engine: top level. Items arrive on
// the request channel and are handled one at a time by a sequencer (mte_ctrl)
// that, while running, drives one step per cycle into a datapath (mte_dpath)
// holding the current, operand and compose-scratch matrices, a single 32x32
// multiplier, an accumulator with one saturation stage and a four-entry result
// fifo. Compose runs 64 multiply steps plus 16 copy steps. Point, direction
// and read first check that the fifo has room for all their results and wait
// there while it has not, so a stalled result channel holds off only those
// items. Products are floored after the 16-bit shift and each output element
// saturates once.
// Depends on mte_pkg, mte_req_if, mte_res_if, mte_ctrl and mte_dpath.
module mat4_transform_engine (
    input  logic        clk,
    input  logic        rst_n,
    mte_req_if.sink     request,
    mte_res_if.source   result
);

    mte_pkg::ctl_cmd_t cmd;
    mte_pkg::dp_stat_t stat;
    logic              idle;

    // one item in flight: ready only while the sequencer is idle
    assign request.ready = idle;

    mte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_kind  (request.kind),
        .req_index (request.elem_index),
        .stat      (stat),
        .idle      (idle),
        .cmd       (cmd)
    );

    mte_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_value (request.elem_value),
        .req_x     (request.coord_x),
        .req_y     (request.coord_y),
        .req_z     (request.coord_z),
        .stat      (stat),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res_value (result.component_value),
        .res_index (result.component_index),
        .res_last  (result.last)
    );

endmodule

FILE: verif/tb_mte_pkg.sv
`timescale 1ns / 1ps
// item and result types for the matrix transform engine testbench
// depends on nothing
package tb_mte_pkg;

    typedef struct {
        logic [3:0]         kind;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } xform_item_t;

    typedef struct {
        logic signed [31:0] component_value;
        logic [1:0]         component_index;
        logic               last;
    } component_t;

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for mat4_transform_engine: directed table then random items,
// every result compared against an in-bench Q16.16 matrix predictor or a hand-written value
// depends on mte_pkg, tb_mte_pkg, mte_req_if, mte_res_if and the engine rtl
module tb_top;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 120;   // longest item (compose) plus margin
    localparam logic signed [31:0] QONE = 32'sh0001_0000;
    localparam logic signed [31:0] QMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] QMIN = 32'sh8000_0000;

    logic clk;
    logic rst_n;

    mte_req_if request ();
    mte_res_if result ();

    mat4_transform_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request.sink),
        .result  (result.source)
    );

    // free-running clock, 12 ns period
    initial clk = 1'b0;
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // predictor state: mirror of the engine's current and operand matrices
    logic signed [31:0] cur_mat [16];
    logic signed [31:0] opr_mat [16];

    tb_mte_pkg::component_t expected_components [$];
    int   error_count = 0;
    int   result_count = 0;
    int   item_count;
    int   cycle_count = 0;
    logic recv_ready = 1'b0;

    // q16.16 product floored toward minus infinity; arithmetic shift does the floor
    function automatic logic signed [63:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p >>> 16;
    endfunction

    // saturate a full-precision sum to the 32-bit word range
    function automatic logic signed [31:0] clamp_word(logic signed [63:0] v);
        if (v > 64'(QMAX))
        begin
            return QMAX;
        end
        if (v < 64'(QMIN))
        begin
            return QMIN;
        end
        return v[31:0];
    endfunction

    task automatic load_identity_model();
        for (int i = 0; i < 16; i++)
        begin
            cur_mat[i] = (i % 5 == 0) ? QONE : 32'sd0;
        end
    endtask

    // advance the matrix model by one item and queue the components it yields
    task automatic predict_transform(tb_mte_pkg::xform_item_t it);
        logic signed [31:0]     nxt [16];
        logic signed [63:0]     acc;
        tb_mte_pkg::component_t c;
        int                     n;
        case (it.kind)
            mte_pkg::KIND_IDENT:   load_identity_model();
            mte_pkg::KIND_WR_CUR:  cur_mat[it.elem_index] = it.elem_value;
            mte_pkg::KIND_WR_OPR:  opr_mat[it.elem_index] = it.elem_value;
            mte_pkg::KIND_COMPOSE:
            begin
                for (int col = 0; col < 4; col++)
                begin
                    for (int row = 0; row < 4; row++)
                    begin
                        acc = 0;
                        for (int k = 0; k < 4; k++)
                        begin
                            acc += qmul(cur_mat[k * 4 + row], opr_mat[col * 4 + k]);
                        end
                        nxt[col * 4 + row] = clamp_word(acc);
                    end
                end
                cur_mat = nxt;
            end
            mte_pkg::KIND_TRANSLATE:
            begin
                for (int row = 0; row < 4; row++)
                begin
                    acc = 64'(cur_mat[12 + row]) + qmul(cur_mat[row], it.coord_x)
                        + qmul(cur_mat[4 + row], it.coord_y) + qmul(cur_mat[8 + row], it.coord_z);
                    cur_mat[12 + row] = clamp_word(acc);
                end
            end
            mte_pkg::KIND_SCALE:
            begin
                for (int row = 0; row < 4; row++)
                begin
                    cur_mat[row]     = clamp_word(qmul(cur_mat[row], it.coord_x));
                    cur_mat[4 + row] = clamp_word(qmul(cur_mat[4 + row], it.coord_y));
                    cur_mat[8 + row] = clamp_word(qmul(cur_mat[8 + row], it.coord_z));
                end
            end
            mte_pkg::KIND_POINT, mte_pkg::KIND_DIR:
            begin
                n = (it.kind == mte_pkg::KIND_POINT) ? 4 : 3;
                for (int row = 0; row < n; row++)
                begin
                    acc = qmul(cur_mat[row], it.coord_x) + qmul(cur_mat[4 + row], it.coord_y)
                        + qmul(cur_mat[8 + row], it.coord_z);
                    if (it.kind == mte_pkg::KIND_POINT)
                    begin
                        acc += 64'(cur_mat[12 + row]);
                    end
                    c.component_value = clamp_word(acc);
                    c.component_index = row[1:0];
                    c.last            = (row == n - 1);
                    expected_components.push_back(c);
                end
            end
            mte_pkg::KIND_READ:
            begin
                c.component_value = cur_mat[it.elem_index];
                c.component_index = 2'd0;
                c.last            = 1'b1;
                expected_components.push_back(c);
            end
            default: ;  // unused kinds do nothing
        endcase
    endtask

    // drive one item at the falling edge and hold it until the engine takes it
    task automatic send_item(tb_mte_pkg::xform_item_t it);
        request.valid      <= 1'b1;
        request.kind       <= it.kind;
        request.elem_index <= it.elem_index;
        request.elem_value <= it.elem_value;
        request.coord_x    <= it.coord_x;
        request.coord_y    <= it.coord_y;
        request.coord_z    <= it.coord_z;
        do
        begin
            @(posedge clk);
        end
        while (!request.ready);
        predict_transform(it);
        item_count++;
        @(negedge clk);
    endtask

    task automatic idle_request(int n);
        request.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_all_results();
        request.valid <= 1'b0;
        while (expected_components.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return QONE;
            1: return -QONE;
            2: return QMAX;
            3: return QMIN;
            4: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic tb_mte_pkg::xform_item_t rand_item(bit wellformed);
        tb_mte_pkg::xform_item_t it;
        it.kind       = wellformed ? 4'($urandom_range(0, 8)) : 4'($urandom_range(0, 15));
        it.elem_index = 4'($urandom_range(0, 15));
        it.elem_value = rand_word();
        it.coord_x    = rand_word();
        it.coord_y    = rand_word();
        it.coord_z    = rand_word();
        return it;
    endfunction

    // receiver: compares each accepted component with the oldest expectation
    always @(posedge clk)
    begin
        tb_mte_pkg::component_t want;
        if (rst_n && result.valid && recv_ready)
        begin
            result_count++;
            if (expected_components.size() == 0)
            begin
                $error("component with nothing expected: value %0d", result.component_value);
                error_count++;
            end
            else
            begin
                want = expected_components.pop_front();
                if (result.component_value !== want.component_value)
                begin
                    $error("component_value: expected %0d actual %0d",
                           want.component_value, result.component_value);
                    error_count++;
                end
                if (result.component_index !== want.component_index)
                begin
                    $error("component_index: expected %0d actual %0d",
                           want.component_index, result.component_index);
                    error_count++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0b actual %0b", want.last, result.last);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern: runs of ready and stall of varying length
    always @(negedge clk)
    begin
        int mode;
        mode = $urandom_range(0, 15);
        if (mode < 6)
        begin
            recv_ready <= 1'b1;
        end
        else if (mode < 12)
        begin
            recv_ready <= $urandom_range(0, 3) != 0;
        end
        else
        begin
            recv_ready <= $urandom_range(0, 3) == 0;
        end
    end
    assign result.ready = recv_ready;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // directed table: extremes of every field, every kind, saturation and flooring
    tb_mte_pkg::xform_item_t directed_items [$];
    logic                    directed_typed [$];
    logic signed [31:0]      directed_expect [$];
    task automatic add_row(logic [3:0] k, logic [3:0] idx, logic signed [31:0] ev,
                           logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
        tb_mte_pkg::xform_item_t it;
        it.kind = k;
        it.elem_index = idx;
        it.elem_value = ev;
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        directed_items.push_back(it);
        directed_typed.push_back(1'b0);
        directed_expect.push_back(32'sd0);
    endtask

    // element read whose value is written out by hand
    task automatic add_read_check(logic [3:0] idx, logic signed [31:0] value);
        add_row(mte_pkg::KIND_READ, idx, 0, 0, 0, 0);
        directed_typed[directed_typed.size() - 1]   = 1'b1;
        directed_expect[directed_expect.size() - 1] = value;
    endtask

    initial
    begin
        tb_mte_pkg::component_t c;
        int burst;
        item_count   = 0;
        request.valid      = 1'b0;
        request.kind       = mte_pkg::KIND_IDENT;
        request.elem_index = 4'd0;
        request.elem_value = 32'sd0;
        request.coord_x    = 32'sd0;
        request.coord_y    = 32'sd0;
        request.coord_z    = 32'sd0;
        for (int i = 0; i < 16; i++)
        begin
            opr_mat[i] = 32'sd0;
        end
        load_identity_model();

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset value of the current matrix read back
        add_read_check(4'd0, QONE);
        add_read_check(4'd15, QONE);
        add_read_check(4'd1, 32'sd0);
        // point through identity with extreme coordinates passes through
        add_row(mte_pkg::KIND_POINT, 4'd0, 0, QMAX, QMIN, -32'sd1);
        // floor of a negative product: -1 lsb times half gives -1
        add_row(mte_pkg::KIND_WR_CUR, 4'd0, -32'sd1, 0, 0, 0);
        add_row(mte_pkg::KIND_DIR, 4'd0, 0, 32'sh0000_8000, 0, 0);
        add_row(mte_pkg::KIND_WR_CUR, 4'd5, QMAX, 0, 0, 0);
        add_row(mte_pkg::KIND_WR_CUR, 4'd10, QMIN, 0, 0, 0);
        // saturation of the sums both ways
        add_row(mte_pkg::KIND_POINT, 4'd0, 0, QMAX, QMAX, QMAX);
        add_row(mte_pkg::KIND_SCALE, 4'd0, 0, QMAX, QMAX, QMIN);
        add_row(mte_pkg::KIND_TRANSLATE, 4'd0, 0, QMIN, QMAX, QMAX);
        add_row(mte_pkg::KIND_READ, 4'd12, 0, 0, 0, 0);
        add_row(mte_pkg::KIND_READ, 4'd13, 0, 0, 0, 0);
        // operand writes and compose, then identity restores
        add_row(mte_pkg::KIND_WR_OPR, 4'd0, QONE, 0, 0, 0);
        add_row(mte_pkg::KIND_WR_OPR, 4'd15, QMIN, 0, 0, 0);
        add_row(mte_pkg::KIND_WR_OPR, 4'd7, QMAX, 0, 0, 0);
        add_row(mte_pkg::KIND_COMPOSE, 4'd0, 0, 0, 0, 0);
        add_row(mte_pkg::KIND_POINT, 4'd0, 0, QONE, -QONE, QONE);
        add_row(mte_pkg::KIND_IDENT, 4'd0, 0, 0, 0, 0);
        add_row(mte_pkg::KIND_TRANSLATE, 4'd0, 0, QONE, 32'sh0002_0000, -QONE);
        add_row(mte_pkg::KIND_POINT, 4'd0, 0, 0, 0, 0);
        // unused kinds change nothing
        add_row(4'd9, 4'd3, QMAX, QMAX, QMAX, QMAX);
        add_row(4'd15, 4'd15, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
        add_row(mte_pkg::KIND_READ, 4'd14, 0, 0, 0, 0);

        foreach (directed_items[i])
        begin
            send_item(directed_items[i]);
            // rows with a hand-written value replace the predicted one
            if (directed_typed[i])
            begin
                c = expected_components.pop_back();
                c.component_value = directed_expect[i];
                expected_components.push_back(c);
            end
        end

        // sender pauses until every expected component is back
        wait_all_results();

        // random part: bursts with gaps; mostly known kinds, some unused kinds
        while (item_count < 450)
        begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst; b++)
            begin
                send_item(rand_item($urandom_range(0, 9) != 0));
            end
            if ($urandom_range(0, 2) != 0)
            begin
                idle_request($urandom_range(1, 12));
            end
            if ($urandom_range(0, 19) == 0)
            begin
                wait_all_results();
            end
        end

        wait_all_results();

        $display("ran %0d items, %0d components checked, all kinds incl. unused and saturating",
                 item_count, result_count);
        if (error_count == 0 && expected_components.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d components outstanding",
                     error_count, expected_components.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mte_pkg.sv
rtl/mte_req_if.sv
rtl/mte_res_if.sv
rtl/mte_ctrl.sv
rtl/mte_dpath.sv
rtl/mat4_transform_engine.sv
verif/tb_mte_pkg.sv
verif/tb_top.sv
